>>> src/swp_pkg.sv
// Shared types, constants and arithmetic helpers for the swash wiggle pattern sequencer.
// No dependencies; imported by swp_ctrl and the top level.
`default_nettype none

package swp_pkg;

    localparam int PIPE_DEPTH = 8;
    localparam int MS_W       = 22;

    localparam logic [1:0] CFG_PULSE_DELTA = 2'd0;
    localparam logic [1:0] CFG_ERROR_LEVEL = 2'd1;
    localparam logic [1:0] CFG_BUZZ_LEVEL  = 2'd2;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_CIRCLE = 2'd1;
    localparam logic [1:0] PH_PULSE  = 2'd2;

    localparam logic [31:0] T_50MS  = 32'd50000;
    localparam logic [31:0] T_100MS = 32'd100000;
    localparam logic [31:0] T_150MS = 32'd150000;
    localparam logic [31:0] T_200MS = 32'd200000;
    localparam logic [31:0] T_300MS = 32'd300000;

    // floor(n / 1000) = (n * MS_RECIP) >> MS_SHIFT for any 32-bit n
    localparam logic [31:0] MS_RECIP = 32'd2199023256;
    localparam int          MS_SHIFT = 41;
    // floor(q / 50) and floor(q / 500) for q below 2^22
    localparam logic [22:0] DIV50_RECIP  = 23'd5368710;
    localparam int          DIV50_SHIFT  = 28;
    localparam logic [22:0] DIV500_RECIP = 23'd4294968;
    localparam int          DIV500_SHIFT = 31;

    typedef enum logic [2:0] {
        ACT_OFF    = 3'd0,
        ACT_READY  = 3'd1,
        ACT_ARMED  = 3'd2,
        ACT_ERROR  = 3'd3,
        ACT_BUZZER = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        RP_KEEP   = 2'd0,
        RP_ZERO   = 2'd1,
        RP_CIRCLE = 2'd2
    } rp_mode_t;

    typedef enum logic [1:0] {
        CO_KEEP = 2'd0,
        CO_SET  = 2'd1,
        CO_ERR  = 2'd2,
        CO_BUZZ = 2'd3
    } co_mode_t;

    typedef struct packed {
        logic               active;
        rp_mode_t           rp_mode;
        co_mode_t           co_mode;
        logic signed [14:0] co_val;
        logic               neg;
        logic [31:0]        mag;
        logic [MS_W-1:0]    ms;
        logic [MS_W-1:0]    turns;
        logic               odd50;
        logic               odd500;
        logic [11:0]        tm;
        logic [11:0]        pos;
        logic signed [16:0] sin_v;
        logic signed [16:0] cos_v;
        logic signed [14:0] roll;
        logic signed [14:0] pitch;
    } swp_pipe_t;

    function automatic logic signed [14:0] sat15(input logic signed [17:0] v);
        logic signed [14:0] r;
        if (v > 18'sd16383)
            r = 15'sd16383;
        else if (v < -18'sd16384)
            r = -15'sd16384;
        else
            r = v[14:0];
        return r;
    endfunction

    function automatic logic [15:0] quarter_sine(input logic [4:0] k);
        logic [15:0] r;
        case (k)
            5'd0:    r = 16'd0;
            5'd1:    r = 16'd3212;
            5'd2:    r = 16'd6393;
            5'd3:    r = 16'd9512;
            5'd4:    r = 16'd12540;
            5'd5:    r = 16'd15447;
            5'd6:    r = 16'd18205;
            5'd7:    r = 16'd20788;
            5'd8:    r = 16'd23170;
            5'd9:    r = 16'd25330;
            5'd10:   r = 16'd27245;
            5'd11:   r = 16'd28899;
            5'd12:   r = 16'd30273;
            5'd13:   r = 16'd31357;
            5'd14:   r = 16'd32138;
            5'd15:   r = 16'd32610;
            default: r = 16'd32768;
        endcase
        return r;
    endfunction

    // sine of a 12-bit angle, Q15, mirrored quarter table with 64-step interpolation
    function automatic logic signed [16:0] sine_q15(input logic [11:0] p);
        logic [10:0] x;
        logic [4:0]  seg;
        logic [5:0]  frac;
        logic [15:0] base;
        logic [11:0] step;
        logic [17:0] prod;
        logic [15:0] v;
        x    = p[10] ? (11'd1024 - {1'b0, p[9:0]}) : {1'b0, p[9:0]};
        seg  = x[10:6];
        frac = x[5:0];
        base = quarter_sine(seg);
        step = 12'(quarter_sine(seg + 5'd1) - base);
        prod = 18'(step) * 18'(frac);
        v    = seg[4] ? 16'd32768 : base + 16'((prod + 18'd32) >> 6);
        return p[11] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // round(|s| * amp / 32768), halves away from zero, sign of s
    function automatic logic signed [14:0] scale_q15(input logic signed [16:0] s,
                                                     input logic [13:0] amp);
        logic [16:0]        mag;
        logic [30:0]        prod;
        logic [15:0]        r;
        logic signed [17:0] sv;
        mag  = s[16] ? 17'(-s) : 17'(s);
        prod = 31'(mag) * 31'(amp);
        r    = 16'((prod + 31'd16384) >> 15);
        sv   = s[16] ? -$signed({2'b0, r}) : $signed({2'b0, r});
        return sat15(sv);
    endfunction

endpackage

`default_nettype wire

>>> src/swash_wiggle_pattern_sequencer_unit.sv
// Swash wiggle pattern sequencer, top level: input register, sequencer, value pipeline, result.
// One item per cycle sustained while out_stall is low, set by the
// sequencer state updating in the single stage after the input register.
// Reset clears the sequencer, the held axis overrides and all valid flags; the config registers take
// their Q-format defaults. Depends on swp_pkg and swp_ctrl.
`default_nettype none

module swash_wiggle_pattern_sequencer_unit
    import swp_pkg::*;
#(
    parameter int CIRCLE_PERIOD_MS = 1200,
    parameter int FRAC_BITS        = 13
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic               operation,
    input  wire logic [2:0]         action,
    input  wire logic [15:0]        duration_ms,
    input  wire logic [31:0]        now_us,
    input  wire logic signed [14:0] collective,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic               active,
    output      logic signed [14:0] roll_out,
    output      logic signed [14:0] pitch_out,
    output      logic signed [14:0] collective_out,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [13:0]        cfg_data
);

    localparam logic [13:0] PULSE_RST = 14'(1 << (FRAC_BITS - 1));
    localparam logic [13:0] ERROR_RST = 14'(((666 << FRAC_BITS) + 500) / 1000);
    localparam logic [13:0] BUZZ_RST  = 14'(1 << (FRAC_BITS - 1));

    localparam int          PW       = $clog2(CIRCLE_PERIOD_MS);
    localparam logic [12:0] PERIOD   = 13'(CIRCLE_PERIOD_MS);
    localparam int          K2       = MS_W + PW;
    localparam logic [63:0] M2_FULL  = ((64'd1 << K2) + 64'(CIRCLE_PERIOD_MS) - 64'd1)
                                       / 64'(CIRCLE_PERIOD_MS);
    localparam logic [23:0] TURN_RECIP = M2_FULL[23:0];
    localparam int          K3       = 24 + PW;
    localparam logic [63:0] M3_FULL  = ((64'd1 << K3) + 64'(CIRCLE_PERIOD_MS) - 64'd1)
                                       / 64'(CIRCLE_PERIOD_MS);
    localparam logic [25:0] POS_RECIP = M3_FULL[25:0];
    localparam int          POS_SHIFT = K3 - 12;

    logic [13:0] pulse_delta_reg;
    logic [13:0] error_level_reg;
    logic [13:0] buzz_level_reg;

    logic                    op_reg;
    logic [2:0]              action_reg;
    logic [15:0]             dur_reg;
    logic [31:0]             now_reg;
    logic signed [14:0]      coll_in_reg;

    logic [PIPE_DEPTH-1:0]   vld_reg, vld_next;
    logic [PIPE_DEPTH:0]     rdy;
    logic                    out_valid_reg;

    swp_pipe_t               pipe_reg  [1:PIPE_DEPTH-1];
    swp_pipe_t               pipe_next [1:PIPE_DEPTH-1];

    logic                    active_reg, active_next;
    logic signed [14:0]      roll_reg, roll_next;
    logic signed [14:0]      pitch_reg, pitch_next;
    logic signed [14:0]      coll_reg, coll_next;

    logic                    accept;

    // ready ripples back from the result register
    always_comb
    begin
        rdy[PIPE_DEPTH] = !out_valid_reg || !out_stall;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k + 1];
        end
    end

    assign in_stall = !rdy[0];
    assign accept   = in_valid && rdy[0];
    assign vld_next = (rdy[PIPE_DEPTH-1:0] & {vld_reg[PIPE_DEPTH-2:0], in_valid})
                    | (~rdy[PIPE_DEPTH-1:0] & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_delta_reg <= PULSE_RST;
            error_level_reg <= ERROR_RST;
            buzz_level_reg  <= BUZZ_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PULSE_DELTA: pulse_delta_reg <= cfg_data;
                CFG_ERROR_LEVEL: error_level_reg <= cfg_data;
                CFG_BUZZ_LEVEL:  buzz_level_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= operation;
            action_reg  <= action;
            dur_reg     <= duration_ms;
            now_reg     <= now_us;
            coll_in_reg <= collective;
        end
    end

    swp_ctrl #(
        .CIRCLE_PERIOD_MS (CIRCLE_PERIOD_MS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (vld_reg[0] && rdy[1]),
        .operation   (op_reg),
        .action      (action_reg),
        .duration_ms (dur_reg),
        .now_us      (now_reg),
        .collective  (coll_in_reg),
        .pulse_delta (pulse_delta_reg),
        .cmd         (pipe_next[1])
    );

    // whole milliseconds
    always_comb
    begin
        logic [63:0] prod;
        pipe_next[2]    = pipe_reg[1];
        prod            = 64'(pipe_reg[1].mag) * 64'(MS_RECIP);
        pipe_next[2].ms = MS_W'(prod >> MS_SHIFT);
    end

    // whole turns and the 50 ms / 500 ms parity
    always_comb
    begin
        logic [45:0] prod_turn;
        logic [44:0] prod_50;
        logic [44:0] prod_500;
        pipe_next[3]        = pipe_reg[2];
        prod_turn           = 46'(pipe_reg[2].ms) * 46'(TURN_RECIP);
        prod_50             = 45'(pipe_reg[2].ms) * 45'(DIV50_RECIP);
        prod_500            = 45'(pipe_reg[2].ms) * 45'(DIV500_RECIP);
        pipe_next[3].turns  = MS_W'(prod_turn >> K2);
        pipe_next[3].odd50  = prod_50[DIV50_SHIFT];
        pipe_next[3].odd500 = prod_500[DIV500_SHIFT];
    end

    // position within the turn, and the square-wave level
    always_comb
    begin
        logic [34:0]        prod;
        logic [MS_W-1:0]    rem;
        logic [12:0]        rem13;
        logic [12:0]        tm13;
        logic signed [14:0] err_v;
        logic signed [14:0] buzz_v;
        pipe_next[4]    = pipe_reg[3];
        prod            = 35'(pipe_reg[3].turns) * 35'(PERIOD);
        rem             = pipe_reg[3].ms - MS_W'(prod);
        rem13           = 13'(rem);
        tm13            = (pipe_reg[3].neg && rem13 != 13'd0) ? PERIOD - rem13 : rem13;
        pipe_next[4].tm = 12'(tm13);
        err_v  = pipe_reg[3].odd50 ? $signed({1'b0, error_level_reg})
                                   : -$signed({1'b0, error_level_reg});
        buzz_v = pipe_reg[3].odd50 ? $signed({1'b0, buzz_level_reg})
                                   : -$signed({1'b0, buzz_level_reg});
        case (pipe_reg[3].co_mode)
            CO_ERR:
            begin
                pipe_next[4].co_mode = CO_SET;
                pipe_next[4].co_val  = err_v;
            end
            CO_BUZZ:
            begin
                pipe_next[4].co_mode = CO_SET;
                pipe_next[4].co_val  = pipe_reg[3].odd500 ? buzz_v : 15'sd0;
            end
            default: ;
        endcase
    end

    // 12-bit angle
    always_comb
    begin
        logic [37:0] prod;
        pipe_next[5]     = pipe_reg[4];
        prod             = 38'(pipe_reg[4].tm) * 38'(POS_RECIP);
        pipe_next[5].pos = 12'(prod >> POS_SHIFT);
    end

    always_comb
    begin
        pipe_next[6]       = pipe_reg[5];
        pipe_next[6].sin_v = sine_q15(pipe_reg[5].pos);
        pipe_next[6].cos_v = sine_q15(pipe_reg[5].pos + 12'd1024);
    end

    always_comb
    begin
        pipe_next[7]       = pipe_reg[6];
        pipe_next[7].roll  = scale_q15(pipe_reg[6].sin_v, pulse_delta_reg);
        pipe_next[7].pitch = scale_q15(pipe_reg[6].cos_v, pulse_delta_reg);
    end

    for (genvar k = 1; k < PIPE_DEPTH; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (rdy[k] && vld_reg[k - 1])
                pipe_reg[k] <= pipe_next[k];
        end
    end

    // apply the item to the held overrides
    always_comb
    begin
        active_next = pipe_reg[PIPE_DEPTH-1].active;
        case (pipe_reg[PIPE_DEPTH-1].rp_mode)
            RP_ZERO:
            begin
                roll_next  = '0;
                pitch_next = '0;
            end
            RP_CIRCLE:
            begin
                roll_next  = pipe_reg[PIPE_DEPTH-1].roll;
                pitch_next = pipe_reg[PIPE_DEPTH-1].pitch;
            end
            default:
            begin
                roll_next  = roll_reg;
                pitch_next = pitch_reg;
            end
        endcase
        case (pipe_reg[PIPE_DEPTH-1].co_mode)
            CO_KEEP: coll_next = coll_reg;
            default: coll_next = pipe_reg[PIPE_DEPTH-1].co_val;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            coll_reg      <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rdy[PIPE_DEPTH])
                out_valid_reg <= vld_reg[PIPE_DEPTH-1];
            if (rdy[PIPE_DEPTH] && vld_reg[PIPE_DEPTH-1])
            begin
                active_reg <= active_next;
                roll_reg   <= roll_next;
                pitch_reg  <= pitch_next;
                coll_reg   <= coll_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign active         = active_reg;
    assign roll_out       = roll_reg;
    assign pitch_out      = pitch_reg;
    assign collective_out = coll_reg;

`ifndef ASSERT_OFF
    a_level_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PIPE_DEPTH-1] |-> (pipe_reg[PIPE_DEPTH-1].co_mode == CO_KEEP
                                   || pipe_reg[PIPE_DEPTH-1].co_mode == CO_SET))
        else $error("square-wave level not resolved before the result stage");

    a_circle_sets_coll: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[PIPE_DEPTH-1] && pipe_reg[PIPE_DEPTH-1].rp_mode == RP_CIRCLE)
        |-> pipe_reg[PIPE_DEPTH-1].co_mode == CO_SET)
        else $error("circle item without a collective value");

    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_reg[PIPE_DEPTH-1]))
        else $error("result appeared without an item in the last stage");
`endif

endmodule

`default_nettype wire

>>> src/swp_ctrl.sv
// Action and phase sequencer: holds action, phase, run length and phase start time.
// Emits one swp_pipe_t command per item for the value datapath; uses swp_pkg.
`default_nettype none

module swp_ctrl
    import swp_pkg::*;
#(
    parameter int CIRCLE_PERIOD_MS = 1200
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               operation,
    input  wire logic [2:0]         action,
    input  wire logic [15:0]        duration_ms,
    input  wire logic [31:0]        now_us,
    input  wire logic signed [14:0] collective,
    input  wire logic [13:0]        pulse_delta,
    output swp_pipe_t               cmd
);

    localparam logic [31:0] CIRCLE_END = 32'(1000 * (CIRCLE_PERIOD_MS + 1));

    logic [2:0]  act_reg, act_next;
    logic [1:0]  ph_reg, ph_next;
    logic [15:0] rl_reg, rl_next;
    logic [31:0] st_reg, st_next;

    always_comb
    begin
        logic [31:0]        start_eff;
        logic [31:0]        sd;
        logic               sd_neg;
        logic [26:0]        run_lim;
        logic               stop;
        logic signed [14:0] lv_minus;
        logic signed [14:0] lv_plus;

        act_next = act_reg;
        ph_next  = ph_reg;
        rl_next  = rl_reg;
        st_next  = st_reg;
        stop     = 1'b0;

        start_eff = (ph_reg == PH_START) ? now_us : st_reg;
        sd        = now_us - start_eff;
        sd_neg    = sd[31];
        run_lim   = 27'((27'(rl_reg) + 27'd1) * 27'd1000);
        lv_minus  = sat15({{3{collective[14]}}, collective} - 18'({4'b0, pulse_delta}));
        lv_plus   = sat15({{3{collective[14]}}, collective} + 18'({4'b0, pulse_delta}));

        cmd         = '0;
        cmd.rp_mode = RP_KEEP;
        cmd.co_mode = CO_KEEP;

        if (operation)
        begin
            act_next = action;
            rl_next  = duration_ms;
            ph_next  = PH_START;
        end
        else if (act_reg == ACT_OFF)
        begin
            act_next = act_reg;
        end
        else if (act_reg > ACT_BUZZER || ph_reg > PH_PULSE
                 || (ph_reg == PH_PULSE && act_reg != ACT_READY))
        begin
            stop = 1'b1;
        end
        else
        begin
            ph_next = (ph_reg == PH_START) ? PH_CIRCLE : ph_reg;
            st_next = start_eff;
            if (ph_reg == PH_START)
            begin
                cmd.rp_mode = RP_ZERO;
                cmd.co_mode = CO_SET;
                cmd.co_val  = '0;
            end
            case (act_reg)
                ACT_READY:
                begin
                    if (ph_reg != PH_PULSE)
                    begin
                        if (!sd_neg && sd >= CIRCLE_END)
                        begin
                            cmd.rp_mode = RP_ZERO;
                            cmd.co_mode = CO_SET;
                            cmd.co_val  = '0;
                            ph_next     = PH_PULSE;
                            st_next     = now_us;
                        end
                        else
                        begin
                            cmd.rp_mode = RP_CIRCLE;
                            cmd.co_mode = CO_SET;
                            cmd.co_val  = collective;
                        end
                    end
                    else
                    begin
                        cmd.co_mode = CO_SET;
                        if (sd_neg || sd < T_100MS)
                            cmd.co_val = collective;
                        else if (sd < T_200MS)
                            cmd.co_val = lv_minus;
                        else if (sd < T_300MS)
                            cmd.co_val = lv_plus;
                        else
                            stop = 1'b1;
                    end
                end
                ACT_ARMED:
                begin
                    cmd.co_mode = CO_SET;
                    if (sd_neg || sd < T_50MS)
                        cmd.co_val = lv_minus;
                    else if (sd < T_100MS)
                        cmd.co_val = collective;
                    else if (sd < T_150MS)
                        cmd.co_val = lv_minus;
                    else
                        stop = 1'b1;
                end
                ACT_ERROR:
                begin
                    cmd.co_mode = CO_ERR;
                    if (!sd_neg && sd >= 32'(run_lim))
                        stop = 1'b1;
                end
                default:
                begin
                    cmd.co_mode = CO_BUZZ;
                    if (!sd_neg && sd >= 32'(run_lim))
                        stop = 1'b1;
                end
            endcase
        end

        if (stop)
        begin
            act_next    = ACT_OFF;
            ph_next     = PH_START;
            st_next     = '0;
            cmd.rp_mode = RP_ZERO;
            cmd.co_mode = CO_SET;
            cmd.co_val  = '0;
        end

        cmd.active = (act_next != ACT_OFF);
        cmd.neg    = sd_neg;
        cmd.mag    = sd_neg ? (32'd0 - sd) : sd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_OFF;
            ph_reg  <= PH_START;
            rl_reg  <= '0;
            st_reg  <= '0;
        end
        else if (advance)
        begin
            act_reg <= act_next;
            ph_reg  <= ph_next;
            rl_reg  <= rl_next;
            st_reg  <= st_next;
        end
    end

endmodule

`default_nettype wire
